// File: rtl/core/ffpa_pkg.sv
// package for the first-fit page allocator
// holds sizes, status codes, payload structs and the cell control struct
package ffpa_pkg;

  localparam int unsigned PoolBytes = 4096;
  localparam int unsigned MaxPages  = 256;
  localparam int unsigned FreeSlots = 32;

  localparam int unsigned LenW  = 13;
  localparam int unsigned OffW  = 12;
  localparam int unsigned IdW   = 8;
  localparam int unsigned CntW  = 6;
  localparam int unsigned SlotW = 5;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StNotFound = 3'd1,
    StNoSpace  = 3'd2,
    StNoIds    = 3'd3,
    StListFull = 3'd4
  } status_e;

  typedef enum logic {
    OpAlloc   = 1'b0,
    OpRelease = 1'b1
  } op_e;

  typedef struct packed {
    logic            operation;
    logic [LenW-1:0] length;
    logic [IdW-1:0]  page_id;
  } req_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [OffW-1:0] offset;
    logic [IdW-1:0]  assigned_id;
    logic            reused_free;
  } rsp_t;

  // command broadcast to every cell of the free list
  typedef struct packed {
    logic            shrink;   // shrink the cell at sel
    logic            remove;   // drop cell sel, cells above take from their right neighbour
    logic            append;   // write the cell at sel with new extent
    logic [SlotW-1:0] sel;
    logic [LenW-1:0]  len;
    logic [OffW-1:0]  new_off;
    logic [LenW-1:0]  new_len;
  } cell_cmd_t;

endpackage

// File: rtl/core/first_fit_page_allocator.sv
// first-fit page allocator: takes one request at a time and stays busy until the result is strobed from the pick state
// free list is a row of 32 cells with a priority pick, page table in a 256 entry memory
// the page table read (registered) and the first-fit pick each get a state of their own: read, then pick
// reset clears counters, pointer and page valid bits at once; no clearing pass
// results are strobed for one cycle; the receiver cannot stall
module first_fit_page_allocator
  import ffpa_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  req_t            req_i,
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_wdata_i,
  output logic            rsp_valid_o,
  output rsp_t            rsp_o
);

  typedef enum logic [3:0] {
    SIdle = 4'b0001,
    SRead = 4'b0010,
    SPick = 4'b0100,
    SDone = 4'b1000
  } state_e;

  state_e state_q, state_d;
  req_t   req_q;
  logic [LenW-1:0] limit_q;
  logic [LenW-1:0] top_q, top_d;
  logic [IdW:0]    idc_q, idc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [MaxPages-1:0] pvalid_q, pvalid_d;
  logic [OffW-1:0] pg_off_mem [MaxPages];
  logic [LenW-1:0] pg_len_mem [MaxPages];
  logic [OffW-1:0] rd_off_q;
  logic [LenW-1:0] rd_len_q;
  logic            pg_we;
  logic [OffW-1:0] pg_woff;
  logic [LenW-1:0] pg_wlen;
  logic            rsp_v_q;
  rsp_t            rsp_q, rsp_d;
  cell_cmd_t       cmd;

  logic [OffW-1:0] c_off [FreeSlots];
  logic [LenW-1:0] c_len [FreeSlots];
  logic [FreeSlots-1:0] c_fit;
  logic [FreeSlots-1:0] fit_q;

  for (genvar g = 0; g < FreeSlots; g++) begin : g_cell
    ffpa_cell u_cell (
      .clk_i     (clk_i),
      .idx_i     (SlotW'(g)),
      .cmd_i     (cmd),
      .nb_off_i  (c_off[(g + 1) % FreeSlots]),
      .nb_len_i  (c_len[(g + 1) % FreeSlots]),
      .req_len_i (req_q.length),
      .off_o     (c_off[g]),
      .len_o     (c_len[g]),
      .fit_o     (c_fit[g])
    );
  end

  // first fit pick from registered flags
  logic            hit;
  logic [SlotW-1:0] hit_idx;
  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    for (int i = FreeSlots - 1; i >= 0; i--) begin
      if (fit_q[i] && CntW'(i) < cnt_q) begin
        hit = 1'b1;
        hit_idx = SlotW'(i);
      end
    end
  end

  logic [LenW-1:0] bound;
  assign bound = (limit_q < LenW'(PoolBytes)) ? limit_q : LenW'(PoolBytes);

  always_comb begin
    state_d  = state_q;
    top_d    = top_q;
    idc_d    = idc_q;
    cnt_d    = cnt_q;
    pvalid_d = pvalid_q;
    rsp_d    = '0;
    cmd      = '0;
    cmd.len  = req_q.length;
    pg_we    = 1'b0;
    pg_woff  = '0;
    pg_wlen  = req_q.length;
    case (state_q)
      SIdle: if (start) state_d = SRead;
      SRead: state_d = SPick;
      SPick: begin
        state_d = SDone;
        if (req_q.operation == OpAlloc) begin
          if (idc_q >= (IdW+1)'(MaxPages)) begin
            rsp_d.status = StNoIds;
          end else if (hit) begin
            cmd.sel = hit_idx;
            if (c_len[hit_idx] > req_q.length) cmd.shrink = 1'b1;
            else begin
              cmd.remove = 1'b1;
              cnt_d = cnt_q - 1'b1;
            end
            pg_we = 1'b1;
            pg_woff = c_off[hit_idx];
            rsp_d.offset = c_off[hit_idx];
            rsp_d.assigned_id = idc_q[IdW-1:0];
            rsp_d.reused_free = 1'b1;
          end else if (top_q > bound || req_q.length > bound - top_q) begin
            rsp_d.status = StNoSpace;
          end else begin
            top_d = top_q + req_q.length;
            pg_we = 1'b1;
            pg_woff = top_q[OffW-1:0];
            rsp_d.offset = top_q[OffW-1:0];
            rsp_d.assigned_id = idc_q[IdW-1:0];
          end
          if (pg_we) begin
            idc_d = idc_q + 1'b1;
            pvalid_d[idc_q[IdW-1:0]] = 1'b1;
          end
        end else begin
          if (!pvalid_q[req_q.page_id]) rsp_d.status = StNotFound;
          else if (cnt_q >= CntW'(FreeSlots)) rsp_d.status = StListFull;
          else begin
            cmd.append = 1'b1;
            cmd.sel = cnt_q[SlotW-1:0];
            cmd.new_off = rd_off_q;
            cmd.new_len = rd_len_q;
            cnt_d = cnt_q + 1'b1;
            pvalid_d[req_q.page_id] = 1'b0;
            rsp_d.offset = rd_off_q;
          end
        end
      end
      SDone: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      limit_q  <= LenW'(PoolBytes);
      top_q    <= '0;
      idc_q    <= '0;
      cnt_q    <= '0;
      pvalid_q <= '0;
      rsp_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      top_q    <= top_d;
      idc_q    <= idc_d;
      cnt_q    <= cnt_d;
      pvalid_q <= pvalid_d;
      rsp_v_q  <= (state_q == SPick);
      if (cfg_we_i) limit_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && start) req_q <= req_i;
    if (state_q == SRead) fit_q <= c_fit;
    rsp_q    <= rsp_d;
    rd_off_q <= pg_off_mem[req_q.page_id];
    rd_len_q <= pg_len_mem[req_q.page_id];
    if (pg_we) begin
      pg_off_mem[idc_q[IdW-1:0]] <= pg_woff;
      pg_len_mem[idc_q[IdW-1:0]] <= pg_wlen;
    end
  end

  assign busy        = (state_q != SIdle);
  assign rsp_valid_o = rsp_v_q;
  assign rsp_o       = rsp_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FreeSlots)) else $error("free count overflow");
  a_rsp_after_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> $past(state_q == SPick)) else $error("stray result");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.shrink, cmd.remove, cmd.append})) else $error("cell command clash");
`endif

endmodule

// File: rtl/core/ffpa_cell.sv
// one free-list slot: holds an extent and compares it against the request
// depends on ffpa_pkg
module ffpa_cell
  import ffpa_pkg::*;
(
  input  logic            clk_i,
  input  logic [SlotW-1:0] idx_i,
  input  cell_cmd_t       cmd_i,
  input  logic [OffW-1:0] nb_off_i,
  input  logic [LenW-1:0] nb_len_i,
  input  logic [LenW-1:0] req_len_i,
  output logic [OffW-1:0] off_o,
  output logic [LenW-1:0] len_o,
  output logic            fit_o
);

  logic [OffW-1:0] off_q, off_d;
  logic [LenW-1:0] len_q, len_d;

  always_comb begin
    off_d = off_q;
    len_d = len_q;
    if (cmd_i.append && cmd_i.sel == idx_i) begin
      off_d = cmd_i.new_off;
      len_d = cmd_i.new_len;
    end else if (cmd_i.shrink && cmd_i.sel == idx_i) begin
      off_d = off_q + cmd_i.len[OffW-1:0];
      len_d = len_q - cmd_i.len;
    end else if (cmd_i.remove && idx_i >= cmd_i.sel) begin
      off_d = nb_off_i;
      len_d = nb_len_i;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q <= off_d;
    len_q <= len_d;
  end

  assign off_o = off_q;
  assign len_o = len_q;
  assign fit_o = (len_q >= req_len_i);

endmodule
